FILE: rtl/telnet_iac_filter_unit_assert.svh
// Assertion macros for the telnet IAC filter checker.
// Expects clk and rst_n in the scope where a macro is used.
`ifndef TELNET_IAC_FILTER_UNIT_ASSERT_SVH
`define TELNET_IAC_FILTER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define TIF_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tif assertion failed");

// Next-cycle implication, disabled during reset
`define TIF_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tif assertion failed");

`endif

FILE: rtl/tif_pkg.sv
// Shared types and telnet byte codes for the telnet IAC filter.
// No dependencies.
`default_nettype none

package tif_pkg;

    localparam logic [7:0] IAC_BYTE   = 8'hFF;
    localparam logic [7:0] GO_AHEAD   = 8'd249;
    localparam logic [7:0] VERB_LIMIT = 8'd250;
    localparam logic [7:0] VERB_WILL  = 8'd251;
    localparam logic [7:0] VERB_WONT  = 8'd252;
    localparam logic [7:0] VERB_DO    = 8'd253;
    localparam logic [7:0] VERB_DONT  = 8'd254;

    localparam logic [7:0] OPT_BINARY = 8'd0;
    localparam logic [7:0] OPT_ECHO   = 8'd1;
    localparam logic [7:0] OPT_SGA    = 8'd3;

    // Input item: cmd set clears negotiation state
    typedef struct packed {
        logic       cmd;
        logic [7:0] in_byte;
        logic       segment_end;
    } in_item_t;

    // Result item: terminal byte or network reply byte
    typedef struct packed {
        logic       to_network;
        logic [7:0] out_byte;
        logic       last;
    } out_item_t;

endpackage

`default_nettype wire

FILE: rtl/telnet_iac_filter_unit.sv
// Top level of the telnet IAC filter: decode, negotiation state, result register.
// Depends on tif_pkg.
`default_nettype none

// Receive-side telnet filter. Each input item is decoded in the cycle it is
// accepted and its results land in a three-byte result register. A plain data
// byte, an escape byte or an option with no reply yields at most one result
// byte, so such items stream at one per cycle while res_stall is low. A
// negotiation reply (IAC, verb, option) is shifted out of the result register
// byte by byte; the input is stalled and the next item is taken in the cycle
// the final reply byte leaves. A clear command (cmd set) resets the state and
// yields no result. segment_end is carried in but does not affect decoding.
module telnet_iac_filter_unit (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              byte_valid,
    output logic                   byte_stall,
    input  wire tif_pkg::in_item_t byte_item,
    output logic                   res_valid,
    input  wire logic              res_stall,
    output tif_pkg::out_item_t     res_item
);
    import tif_pkg::*;

    // negotiation state
    logic       in_escape_reg, in_escape_next;
    logic       awaiting_option_reg, awaiting_option_next;
    logic [7:0] pending_verb_reg, pending_verb_next;
    logic       peer_binary_reg, peer_binary_next;

    // result register: up to three bytes, shifted out from byte0
    logic       res_valid_reg, res_valid_next;
    logic [1:0] remain_reg, remain_next;
    logic       net_reg, net_next;
    logic [7:0] byte0_reg, byte0_next;
    logic [7:0] byte1_reg, byte1_next;
    logic [7:0] byte2_reg, byte2_next;

    logic       accept;
    logic       take_last;
    logic [7:0] c;
    logic       known;
    logic       do_data;
    logic       do_reply;
    logic [7:0] data_byte;
    logic [7:0] reply_verb;
    logic [7:0] reply_opt;

    // take the next item once the result register is empty or its final byte leaves
    assign take_last  = res_valid_reg && !res_stall && (remain_reg == 2'd1);
    assign byte_stall = res_valid_reg && !take_last;
    assign accept     = byte_valid && !byte_stall;
    assign c          = byte_item.in_byte;
    assign known      = (c == OPT_BINARY) || (c == OPT_ECHO) || (c == OPT_SGA);

    // decode one byte against the current state
    always_comb
    begin
        in_escape_next       = in_escape_reg;
        awaiting_option_next = awaiting_option_reg;
        pending_verb_next    = pending_verb_reg;
        peer_binary_next     = peer_binary_reg;
        do_data              = 1'b0;
        do_reply             = 1'b0;
        data_byte            = c;
        reply_verb           = VERB_WONT;
        reply_opt            = c;
        if (byte_item.cmd)
        begin
            in_escape_next       = 1'b0;
            awaiting_option_next = 1'b0;
            pending_verb_next    = 8'd0;
            peer_binary_next     = 1'b0;
        end
        else if (!in_escape_reg)
        begin
            if (c == IAC_BYTE)
                in_escape_next = 1'b1;
            else
                do_data = 1'b1;
        end
        else if (!awaiting_option_reg)
        begin
            if (c == GO_AHEAD)
            begin
                in_escape_next = 1'b0;
            end
            else
            begin
                pending_verb_next    = c;
                awaiting_option_next = 1'b1;
                // escaped 0xFF in binary mode is a literal data byte
                if (peer_binary_reg && (c == IAC_BYTE))
                begin
                    in_escape_next       = 1'b0;
                    awaiting_option_next = 1'b0;
                    do_data              = 1'b1;
                end
            end
        end
        else
        begin
            // option byte: reject unknown options under any verb above VERB_LIMIT (negotiation verbs and 0xFF)
            if (!known && (pending_verb_reg > VERB_LIMIT))
                do_reply = 1'b1;
            case (pending_verb_reg)
                VERB_WILL:
                begin
                    if (c == OPT_BINARY)
                        peer_binary_next = 1'b1;
                end
                VERB_WONT:
                begin
                    if (c == OPT_BINARY)
                        peer_binary_next = 1'b0;
                end
                VERB_DO, VERB_DONT:
                begin
                    if (c == OPT_BINARY)
                    begin
                        do_reply   = 1'b1;
                        reply_verb = (pending_verb_reg == VERB_DO) ? VERB_WILL : VERB_WONT;
                    end
                    else if (c == OPT_ECHO)
                    begin
                        do_reply   = 1'b1;
                        reply_verb = VERB_WONT;
                    end
                    else if (c == OPT_SGA)
                    begin
                        do_reply   = 1'b1;
                        reply_verb = VERB_WILL;
                    end
                end
                default:
                begin
                end
            endcase
            in_escape_next       = 1'b0;
            awaiting_option_next = 1'b0;
        end
    end

    // load or advance the result register
    always_comb
    begin
        res_valid_next = res_valid_reg;
        remain_next    = remain_reg;
        net_next       = net_reg;
        byte0_next     = byte0_reg;
        byte1_next     = byte1_reg;
        byte2_next     = byte2_reg;
        if (accept)
        begin
            res_valid_next = do_data || do_reply;
            net_next       = do_reply;
            remain_next    = do_reply ? 2'd3 : 2'd1;
            byte0_next     = do_reply ? IAC_BYTE : data_byte;
            byte1_next     = reply_verb;
            byte2_next     = reply_opt;
        end
        else if (res_valid_reg && !res_stall)
        begin
            // empty once the final byte leaves
            res_valid_next = (remain_reg != 2'd1);
            remain_next    = remain_reg - 2'd1;
            byte0_next     = byte1_reg;
            byte1_next     = byte2_reg;
        end
    end

    // hold state and the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_escape_reg       <= 1'b0;
            awaiting_option_reg <= 1'b0;
            pending_verb_reg    <= 8'd0;
            peer_binary_reg     <= 1'b0;
            res_valid_reg       <= 1'b0;
            remain_reg          <= 2'd0;
        end
        else
        begin
            if (accept)
            begin
                in_escape_reg       <= in_escape_next;
                awaiting_option_reg <= awaiting_option_next;
                pending_verb_reg    <= pending_verb_next;
                peer_binary_reg     <= peer_binary_next;
            end
            res_valid_reg <= res_valid_next;
            remain_reg    <= remain_next;
        end
    end

    // payload needs no reset
    always_ff @(posedge clk)
    begin
        net_reg   <= net_next;
        byte0_reg <= byte0_next;
        byte1_reg <= byte1_next;
        byte2_reg <= byte2_next;
    end

    assign res_valid           = res_valid_reg;
    assign res_item.to_network = net_reg;
    assign res_item.out_byte   = byte0_reg;
    assign res_item.last       = (remain_reg == 2'd1);

endmodule

`default_nettype wire

FILE: rtl/tif_checker.sv
// Port-level checker for the telnet IAC filter, bound to the top level.
// Depends on tif_pkg and telnet_iac_filter_unit_assert.svh.
`default_nettype none

`include "telnet_iac_filter_unit_assert.svh"

module tif_checker (
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               byte_valid,
    input wire logic               byte_stall,
    input wire tif_pkg::in_item_t  byte_item,
    input wire logic               res_valid,
    input wire logic               res_stall,
    input wire tif_pkg::out_item_t res_item
);
    import tif_pkg::*;

    // a stalled result item holds
    `TIF_ASSERT_NEXT(a_res_hold, res_valid && res_stall, res_valid && $stable(res_item))

    // only reply bytes come in groups, and the group continues without a gap
    `TIF_ASSERT_NEXT(a_reply_cont, res_valid && !res_stall && !res_item.last,
                     res_valid && res_item.to_network)

    // input waits while a reply is still going out
    `TIF_ASSERT_IMPL(a_stall_reply, res_valid && !res_item.last, byte_stall)

    // a clear command yields no result
    `TIF_ASSERT_NEXT(a_clear_quiet, byte_valid && !byte_stall && byte_item.cmd, !res_valid)

endmodule

bind telnet_iac_filter_unit tif_checker u_tif_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .byte_valid (byte_valid),
    .byte_stall (byte_stall),
    .byte_item  (byte_item),
    .res_valid  (res_valid),
    .res_stall  (res_stall),
    .res_item   (res_item)
);

`default_nettype wire

FILE: verif/tb.sv
// Self-checking testbench for telnet_iac_filter_unit: random and directed byte streams,
// an in-bench predictor of the IAC filter, and result checks under random idle and stall.
// Depends on tif_pkg and the telnet_iac_filter_unit RTL.
`default_nettype none

module tb;
    import tif_pkg::*;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int PHASE_ITEMS   = 74;
    localparam int SETTLE_CYCLES = 8;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      byte_valid = 1'b0;
    logic      byte_stall;
    in_item_t  byte_item = '0;
    logic      res_valid;
    logic      res_stall = 1'b0;
    out_item_t res_item;

    // Bytes waiting to be offered, and results the filter still owes
    in_item_t  byte_backlog[$];
    out_item_t expected_out[$];

    // Predictor copy of the negotiation state
    logic       esc_seen   = 1'b0;
    logic       opt_next   = 1'b0;
    logic [7:0] held_verb  = 8'h00;
    logic       binary_on  = 1'b0;

    int  send_idle_pct  = 0;
    int  recv_stall_pct = 0;
    bit  byte_taken     = 1'b0;
    int  cycle_count    = 0;
    int  err_count      = 0;
    int  items_sent     = 0;
    int  results_seen   = 0;
    int  replies_seen   = 0;
    int  phase_items    = 0;

    telnet_iac_filter_unit u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_stall (byte_stall),
        .byte_item  (byte_item),
        .res_valid  (res_valid),
        .res_stall  (res_stall),
        .res_item   (res_item)
    );

    // Free-running clock, period 12
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    // Print one mismatch line and count it
    task automatic report_mismatch(input string what, input int got, input int want);
        $display("MISMATCH at cycle %0d: %s got %0d expected %0d", cycle_count, what, got, want);
        err_count++;
    endtask

    // Work out the results of one accepted byte and queue them in order
    task automatic filter_predict(input in_item_t it);
        out_item_t  res_buf[3];
        int         n;
        logic [7:0] c;
        logic       known_opt;
        n = 0;
        c = it.in_byte;
        if (it.cmd)
        begin
            esc_seen  = 1'b0;
            opt_next  = 1'b0;
            held_verb = 8'h00;
            binary_on = 1'b0;
        end
        else if (!esc_seen)
        begin
            if (c == IAC_BYTE)
                esc_seen = 1'b1;
            else
            begin
                res_buf[n] = '{to_network: 1'b0, out_byte: c, last: 1'b0};
                n++;
            end
        end
        else if (!opt_next)
        begin
            if (c == GO_AHEAD)
                esc_seen = 1'b0;
            else
            begin
                held_verb = c;
                opt_next  = 1'b1;
                // IAC IAC in binary mode is one literal 0xFF
                if (binary_on && c == IAC_BYTE)
                begin
                    esc_seen = 1'b0;
                    opt_next = 1'b0;
                    res_buf[n] = '{to_network: 1'b0, out_byte: IAC_BYTE, last: 1'b0};
                    n++;
                end
            end
        end
        else
        begin
            logic [7:0] rverb;
            logic [7:0] ropt;
            logic       reply;
            known_opt = (c == OPT_BINARY) || (c == OPT_ECHO) || (c == OPT_SGA);
            reply = 1'b0;
            rverb = VERB_WONT;
            ropt  = c;
            // Refuse unknown options for any verb above the limit
            if (!known_opt && held_verb > VERB_LIMIT)
                reply = 1'b1;
            if (held_verb == VERB_WILL && c == OPT_BINARY)
                binary_on = 1'b1;
            else if (held_verb == VERB_WONT && c == OPT_BINARY)
                binary_on = 1'b0;
            else if (held_verb == VERB_DO || held_verb == VERB_DONT)
            begin
                if (c == OPT_SGA)
                begin
                    reply = 1'b1;
                    rverb = VERB_WILL;
                end
                else if (c == OPT_ECHO)
                    reply = 1'b1;
                else if (c == OPT_BINARY)
                begin
                    reply = 1'b1;
                    rverb = (held_verb == VERB_DO) ? VERB_WILL : VERB_WONT;
                end
            end
            if (reply)
            begin
                res_buf[0] = '{to_network: 1'b1, out_byte: IAC_BYTE, last: 1'b0};
                res_buf[1] = '{to_network: 1'b1, out_byte: rverb, last: 1'b0};
                res_buf[2] = '{to_network: 1'b1, out_byte: ropt, last: 1'b0};
                n = 3;
            end
            esc_seen = 1'b0;
            opt_next = 1'b0;
        end
        if (n > 0)
            res_buf[n - 1].last = 1'b1;
        for (int i = 0; i < n; i++)
            expected_out = {expected_out, res_buf[i]};
    endtask

    // Queue one byte item with a random segment_end
    task automatic add_byte(input logic cmd, input logic [7:0] b);
        in_item_t it;
        it.cmd         = cmd;
        it.in_byte     = b;
        it.segment_end = 1'($urandom_range(0, 1));
        byte_backlog   = {byte_backlog, it};
        phase_items++;
    endtask

    task automatic add_nego(input logic [7:0] verb, input logic [7:0] opt);
        add_byte(1'b0, IAC_BYTE);
        add_byte(1'b0, verb);
        add_byte(1'b0, opt);
    endtask

    // Queue one random sequence: negotiation, escapes, plain data, noise and clear commands
    task automatic add_random_seq();
        int         pick;
        logic [7:0] verb;
        logic [7:0] opt;
        pick = $urandom_range(0, 99);
        case ($urandom_range(0, 7))
            0, 1:    verb = VERB_WILL;
            2:       verb = VERB_WONT;
            3, 4:    verb = VERB_DO;
            5:       verb = VERB_DONT;
            6:       verb = IAC_BYTE;
            default: verb = 8'($urandom_range(0, 255));
        endcase
        case ($urandom_range(0, 4))
            0:       opt = OPT_BINARY;
            1:       opt = OPT_ECHO;
            2:       opt = OPT_SGA;
            3:       opt = 8'($urandom_range(0, 3));
            default: opt = 8'($urandom_range(0, 255));
        endcase
        if (pick < 40)
            add_nego(verb, opt);
        else if (pick < 50)
        begin
            add_byte(1'b0, IAC_BYTE);
            add_byte(1'b0, IAC_BYTE);
        end
        else if (pick < 55)
        begin
            add_byte(1'b0, IAC_BYTE);
            add_byte(1'b0, GO_AHEAD);
        end
        else if (pick < 82)
            add_byte(1'b0, 8'($urandom_range(0, 254)));
        else if (pick < 92)
            add_byte(1'b0, 8'($urandom_range(0, 255)));
        else if (pick < 97)
        begin
            // Break a sequence with a clear command
            add_byte(1'b0, IAC_BYTE);
            if ($urandom_range(0, 1))
                add_byte(1'b0, verb);
            add_byte(1'b1, 8'($urandom_range(0, 255)));
        end
        else
            add_byte(1'b1, 8'($urandom_range(0, 255)));
    endtask

    // Hold off new items until all offered ones are taken and every result is in
    task automatic drain_all();
        while (!(byte_backlog.size() == 0 && !byte_valid))
            @(posedge clk);
        while (expected_out.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic run_random_phase(input int idle_pct, input int stall_pct);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        phase_items    = 0;
        while (phase_items < PHASE_ITEMS)
            add_random_seq();
        drain_all();
    endtask

    // Driver: offer items and stall results at the falling edge
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            byte_valid <= 1'b0;
            res_stall  <= 1'b0;
        end
        else
        begin
            // Advance to the next item once the current one is taken or none is shown
            if (!byte_valid || byte_taken)
            begin
                if (byte_backlog.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    byte_item  <= byte_backlog.pop_front();
                    byte_valid <= 1'b1;
                end
                else
                    byte_valid <= 1'b0;
            end
            res_stall <= ($urandom_range(0, 99) < recv_stall_pct);
        end
    end

    // Monitor: predict on accepted bytes, then check accepted results
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            byte_taken = byte_valid && !byte_stall;
            if (byte_taken)
            begin
                filter_predict(byte_item);
                items_sent++;
            end
            if (res_valid && !res_stall)
            begin
                results_seen++;
                if (res_item.to_network)
                    replies_seen++;
                if (expected_out.size() == 0)
                    report_mismatch("unexpected result, out_byte", res_item.out_byte, -1);
                else
                begin
                    out_item_t want;
                    want = expected_out.pop_front();
                    if (res_item.to_network !== want.to_network)
                        report_mismatch("to_network", res_item.to_network, want.to_network);
                    if (res_item.out_byte !== want.out_byte)
                        report_mismatch("out_byte", res_item.out_byte, want.out_byte);
                    if (res_item.last !== want.last)
                        report_mismatch("last", res_item.last, want.last);
                end
            end
        end
    end

    // Stop a hung run
    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("Timeout after %0d cycles, %0d results still owed", cycle_count,
                 expected_out.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        repeat (4) @(posedge clk);
        @(negedge clk);
        #3 rst_n = 1'b1;

        // Directed: data extremes, go-ahead, replies, binary mode, unknown verbs, clear
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        add_byte(1'b0, 8'h00);
        add_byte(1'b0, 8'hFE);
        add_byte(1'b0, IAC_BYTE);
        add_byte(1'b0, GO_AHEAD);
        add_nego(VERB_DO, OPT_ECHO);
        add_nego(VERB_DONT, OPT_SGA);
        add_nego(VERB_WILL, OPT_BINARY);
        add_byte(1'b0, IAC_BYTE);
        add_byte(1'b0, IAC_BYTE);
        add_nego(VERB_WONT, OPT_BINARY);
        add_nego(IAC_BYTE, 8'd7);
        add_byte(1'b0, IAC_BYTE);
        add_byte(1'b0, VERB_LIMIT);
        add_byte(1'b1, 8'hA5);
        add_byte(1'b0, 8'h41);
        drain_all();

        run_random_phase(0, 0);
        run_random_phase(60, 0);
        run_random_phase(0, 60);
        run_random_phase(29, 29);

        $display("Covered %0d input items and %0d results (%0d network reply bytes)",
                 items_sent, results_seen, replies_seen);
        $display("Phases: directed, then random with no idling, sender idle, receiver stall, both");
        if (err_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

`default_nettype wire
